/* src/i2a_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared constants, codes and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int DIGIT_W        = 4;
  localparam int FIELD_W        = 64;
  localparam int IN_DATA_W      = 72;
  localparam int CHAR_W         = 8;

  localparam logic [1:0] ACTION_UNSIGNED = 2'd0;
  localparam logic [1:0] ACTION_SIGNED   = 2'd1;
  localparam logic [1:0] ACTION_HEX      = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Decimal digits needed for an unsigned word of the given width
  // (floor(bits * log10(2)) + 1).
  function automatic int dec_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

  // Uppercase hex glyph of one digit.
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d8;
    d8 = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + d8;
    end else begin
      return CHAR_UPPER + d8 - 8'd10;
    end
  endfunction

endpackage

/* src/i2a_dabble.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_dabble
// Bit-serial double-dabble converter and digit shift register.
// ----------------------------------------------------------------------------
module i2a_dabble
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  hex_i,
  input  logic [VALUE_BITS-1:0] word_i,
  input  logic                  shift_i,
  output logic                  busy_o,
  output logic [DIGIT_W-1:0]    top_o
);

  localparam int NDIG = dec_digits(VALUE_BITS);
  localparam int DW   = NDIG * DIGIT_W;
  localparam int CW   = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin_q;
  logic [DW-1:0]         dig_q;
  logic [DW-1:0]         adj;
  logic [CW-1:0]         cnt_q;
  logic                  busy_q;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      if (dig_q[k*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[k*DIGIT_W +: DIGIT_W] = dig_q[k*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[k*DIGIT_W +: DIGIT_W] = dig_q[k*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !hex_i;
      cnt_q  <= CW'(VALUE_BITS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= word_i;
      dig_q <= hex_i ? {{(DW-VALUE_BITS){1'b0}}, word_i} : '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
      dig_q <= {adj[DW-2:0], bin_q[VALUE_BITS-1]};
    end else if (shift_i) begin
      dig_q <= {dig_q[DW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign busy_o = busy_q;
  assign top_o  = dig_q[DW-1 -: DIGIT_W];

endmodule

/* src/integer_to_ascii_formatter_top.sv */
`timescale 1ns / 1ps
// Sequence: a load, then bit-serial double dabble over VALUE_BITS bits in
//   decimal modes (none in hex), then each prefix or sign character, then
//   each digit slot of the dec_digits(VALUE_BITS) digit shift register.
// Flow: one word at a time; the next word is taken only once the last character
//   of this one is in the output register, and output stalls hold the sequence.
// Reset: asynchronous active low; clears the sequencer and the output beat.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats a word as unsigned decimal, signed decimal or 0x-prefixed hex text,
// one ASCII character per output beat, most significant first.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,  // [1:0] action, [65:2] value
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [CHAR_W-1:0]    m_axis_tdata_o,  // [7:0] char_code
  output logic                 m_axis_tlast_o   // last
);

  localparam int NDIG = dec_digits(VALUE_BITS);
  localparam int RW   = $clog2(NDIG + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_HEX0  = 6'b000100,
    ST_HEXX  = 6'b001000,
    ST_MINUS = 6'b010000,
    ST_DIGIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]            action;
  logic [VALUE_BITS-1:0] word;
  logic [VALUE_BITS-1:0] mag;
  logic                  accept;
  logic                  hex_in;
  logic                  neg_in;

  logic                  hex_q, hex_d;
  logic                  neg_q, neg_d;
  logic                  seen_q, seen_d;
  logic [RW-1:0]         rem_q, rem_d;

  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic                  slot_free;

  logic                  dab_busy;
  logic                  dab_shift;
  logic [DIGIT_W-1:0]    top_digit;

  // Unpack the beat; bits above the value field are dropped.
  assign action = s_axis_tdata_i[1:0];
  assign word   = s_axis_tdata_i[2 +: VALUE_BITS];
  assign hex_in = (action == ACTION_HEX);
  assign neg_in = (action == ACTION_SIGNED) && word[VALUE_BITS-1];
  // Two's complement magnitude; the most negative word maps to itself, which
  // is already its correct unsigned magnitude.
  assign mag    = neg_in ? ((~word) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : word;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // The output register may take a new character when empty or draining.
  assign slot_free = !out_valid_q || m_axis_tready_i;

  i2a_dabble #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .hex_i  (hex_in),
    .word_i (mag),
    .shift_i(dab_shift),
    .busy_o (dab_busy),
    .top_o  (top_digit)
  );

  always_comb begin
    state_d     = state_q;
    hex_d       = hex_q;
    neg_d       = neg_q;
    seen_d      = seen_q;
    rem_d       = rem_q;
    dab_shift   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          hex_d   = hex_in;
          neg_d   = neg_in;
          seen_d  = 1'b0;
          rem_d   = RW'(NDIG);
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        // Wait for the converter; hex digits are ready at once.
        if (!dab_busy) begin
          if (hex_q) begin
            state_d = ST_HEX0;
          end else if (neg_q) begin
            state_d = ST_MINUS;
          end else begin
            state_d = ST_DIGIT;
          end
        end
      end
      ST_HEX0: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_ZERO;
          out_last_d  = 1'b0;
          state_d     = ST_HEXX;
        end
      end
      ST_HEXX: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_X;
          out_last_d  = 1'b0;
          state_d     = ST_DIGIT;
        end
      end
      ST_MINUS: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        // Drop leading zeros, but always print the final digit slot.
        if (!seen_q && (top_digit == '0) && (rem_q != RW'(1))) begin
          dab_shift = 1'b1;
          rem_d     = rem_q - 1'b1;
        end else if (slot_free) begin
          dab_shift   = 1'b1;
          rem_d       = rem_q - 1'b1;
          seen_d      = 1'b1;
          out_valid_d = 1'b1;
          out_char_d  = glyph(top_digit);
          out_last_d  = (rem_q == RW'(1));
          if (rem_q == RW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hex_q       <= 1'b0;
      neg_q       <= 1'b0;
      seen_q      <= 1'b0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hex_q       <= hex_d;
      neg_q       <= neg_d;
      seen_q      <= seen_d;
      rem_q       <= rem_d;
    end
  end

  // Output beat payload; holds while the beat is stalled.
  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to ASCII formatter. Words go in as
// single beats with a mode, and every character that comes out is checked,
// with its last flag, against text worked out here. Directed corner words come
// first, then a long output hold-off, then a random run with bursty input and
// a patterned output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import i2a_pkg::*;

  localparam int          WORD_BITS   = VALUE_BITS_DEF;
  localparam logic [1:0]  ACTION_SPARE = 2'd3;  // unused code, prints as unsigned
  localparam string       HEX_GLYPHS  = "0123456789ABCDEF";
  localparam int          TAIL_CYCLES = 200;    // longer than one decimal word
  localparam int          HOLD_CYCLES = 400;
  localparam int          RANDOM_WORDS = 470;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } text_char_t;

  // Output stall styles, each held for a random stretch.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_HALF,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_style_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [CHAR_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;

  logic                 rx_hold = 1'b0;  // forces the output stall while high
  text_char_t           pending_chars[$];
  int                   mismatch_count = 0;
  int                   burst_left = 0;
  rx_style_e            rx_style = RX_FREE;
  int                   rx_style_left = 0;
  int                   rx_phase = 0;
  logic                 rx_want;

  integer_to_ascii_formatter_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),   // [1:0] action, [65:2] value
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),   // [7:0] char_code
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatch_count < 100) begin
      $display("MISMATCH %s: expected %0h, got %0h at %0t ns", what, want, got, $time);
    end
    mismatch_count++;
  endtask

  // Work out the text of one word and queue its characters, most
  // significant first, with last set on the final one.
  function automatic void predict_text(input logic [1:0] act, input logic [63:0] word);
    logic [CHAR_W-1:0] rev[$];
    logic [CHAR_W-1:0] txt[$];
    logic [63:0]       mag;
    text_char_t        ch;
    mag = word;
    if (act == ACTION_HEX) begin
      txt.push_back(CHAR_ZERO);
      txt.push_back(CHAR_X);
      do begin
        rev.push_back(HEX_GLYPHS[mag[3:0]]);
        mag = mag >> 4;
      end while (mag != 0);
    end else begin
      // The spare code falls through here as plain unsigned.
      if (act == ACTION_SIGNED && word[WORD_BITS-1]) begin
        txt.push_back(CHAR_MINUS);
        mag = ~word + 64'd1;  // most negative word maps onto itself, read unsigned
      end
      do begin
        rev.push_back(CHAR_ZERO + CHAR_W'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 0);
    end
    while (rev.size() != 0) begin
      txt.push_back(rev.pop_back());
    end
    foreach (txt[k]) begin
      ch.char_code = txt[k];
      ch.last      = (k == txt.size() - 1);
      pending_chars.push_back(ch);
    end
  endfunction

  // Offer one word and hold it until the block takes it. Runs in bursts:
  // when a burst is used up, drop valid for a random gap first.
  task automatic send_word(input logic [1:0] act, input logic [63:0] word);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - 66){1'b0}}, word, act};
    // Sample ready mid-cycle; the beat moves at the following rising edge.
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    predict_text(act, word);
  endtask

  // Pause the input until every queued character has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  function automatic logic [1:0] rand_action();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) return ACTION_UNSIGNED;
    if (pick < 6) return ACTION_SIGNED;
    if (pick < 9) return ACTION_HEX;
    return ACTION_SPARE;
  endfunction

  // Mix of full-width words, short ones, powers of ten and sign boundaries.
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    int          n;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      3: w = 64'($urandom_range(0, 1000));
      4: begin
        w = 64'd1;
        n = $urandom_range(0, 19);
        repeat (n) w = w * 64'd10;
        w = w + 64'($urandom_range(0, 2)) - 64'd1;
      end
      5: w = w >> $urandom_range(1, 63);
      6: w = ($urandom_range(0, 1) == 0) ? {1'b1, 63'd0} + 64'($urandom_range(0, 3))
                                        : {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
      7: w = {64{1'b1}} >> $urandom_range(0, 63);
      default: ;
    endcase
    return w;
  endfunction

  // Field extremes, every mode, zero, the most negative word and the spare code.
  task automatic test_corner_values();
    send_word(ACTION_UNSIGNED, 64'd0);
    send_word(ACTION_UNSIGNED, 64'd1);
    send_word(ACTION_UNSIGNED, 64'd9);
    send_word(ACTION_UNSIGNED, 64'd10);
    send_word(ACTION_UNSIGNED, 64'd9999999999999999999);
    send_word(ACTION_UNSIGNED, 64'd10000000000000000000);
    send_word(ACTION_UNSIGNED, {64{1'b1}});
    send_word(ACTION_SIGNED, 64'd0);
    send_word(ACTION_SIGNED, {64{1'b1}});
    send_word(ACTION_SIGNED, {1'b0, {63{1'b1}}});
    send_word(ACTION_SIGNED, {1'b1, 63'd0});
    send_word(ACTION_SIGNED, -64'sd10);
    send_word(ACTION_SIGNED, 64'd7);
    send_word(ACTION_HEX, 64'd0);
    send_word(ACTION_HEX, 64'd1);
    send_word(ACTION_HEX, 64'hA);
    send_word(ACTION_HEX, 64'h0123_4567_89AB_CDEF);
    send_word(ACTION_HEX, 64'hFEDC_BA98_7654_3210);
    send_word(ACTION_HEX, {64{1'b1}});
    send_word(ACTION_SPARE, {1'b1, 63'd0});
    send_word(ACTION_SPARE, 64'd12345);
    send_word(ACTION_SPARE, 64'd0);
  endtask

  // Hold the output off for a long stretch while words keep coming, so the
  // block backs up and stalls its input.
  task automatic test_output_hold_off();
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        repeat (8) send_word(rand_action(), rand_word());
      end
    join
  endtask

  // Bulk random words, with an occasional full drain in between.
  task automatic test_random_words(input int count);
    repeat (count) begin
      send_word(rand_action(), rand_word());
      if ($urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  // Output ready: switch style every so often, and obey the hold-off flag.
  always @(posedge clk_i) begin
    if (rx_style_left == 0) begin
      rx_style      = rx_style_e'($urandom_range(0, 3));
      rx_style_left = $urandom_range(20, 200);
    end else begin
      rx_style_left--;
    end
    rx_phase = (rx_phase == 2) ? 0 : rx_phase + 1;
    case (rx_style)
      RX_FREE:        rx_want = 1'b1;
      RX_HALF:        rx_want = ($urandom_range(0, 1) == 0);
      RX_SPARSE:      rx_want = ($urandom_range(0, 3) == 0);
      RX_EVERY_THIRD: rx_want = (rx_phase == 0);
      default:        rx_want = 1'b1;
    endcase
    m_axis_tready <= rx_want && !rx_hold;
  end

  // Check each output beat against the oldest queued character.
  always @(negedge clk_i) begin
    text_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected char", 64'd0, 64'(m_axis_tdata));
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.char_code) begin
          report_mismatch("char_code", 64'(want.char_code), 64'(m_axis_tdata));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last", 64'(want.last), 64'(m_axis_tlast));
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_values();
    drain_results();
    test_output_hold_off();
    drain_results();
    test_random_words(RANDOM_WORDS);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      report_mismatch("chars never seen", 64'(pending_chars.size()), 64'd0);
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
